### hw/rtl/edge_delta_varint_encoder_assert.svh
// ---------------------------------------------------------------------------
// Edge delta varint encoder: assertion macros
// Clocked implication checks, same-cycle and next-cycle forms.
// ---------------------------------------------------------------------------
`ifndef EDGE_DELTA_VARINT_ENCODER_ASSERT_SVH
`define EDGE_DELTA_VARINT_ENCODER_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define EDV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edvenc check failed");

// antecedent holds -> consequent holds in the next cycle
`define EDV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edvenc check failed");

`endif

### hw/rtl/edvenc_pkg.sv
// ---------------------------------------------------------------------------
// Edge delta varint encoder: package
// Widths, byte-coding constants, controller states and the command and
// status groups between controller and datapath.
// ---------------------------------------------------------------------------
package edvenc_pkg;

  localparam int SRC_W      = 31;
  localparam int VAL_W      = 32;
  localparam int OFS_W      = 48;
  localparam int BYTE_W     = 8;
  localparam int IN_TDATA_W = 112;  // 31 + 32 + 48 = 111, padded to bytes
  localparam int OUT_TDATA_W = 56;  // 8 + 48

  localparam logic [BYTE_W-1:0] CONT_BIT  = 8'h80;
  localparam logic [BYTE_W-1:0] SIGN_BIT  = 8'h40;
  localparam logic [BYTE_W-1:0] LOW6_MASK = 8'h3f;
  localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7f;

  localparam logic ACT_FIRST = 1'b0;
  localparam logic ACT_GAP   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;   // capture a new edge
    logic emit;   // move the next coded byte into the output register
  } cmd_t;

  typedef struct packed {
    logic zero_gap;   // incoming edge codes to nothing
    logic slot_free;  // output register can take a byte this cycle
    logic last_byte;  // byte on offer is the final one of the edge
  } sts_t;

endpackage

### hw/rtl/edvenc_ctrl.sv
// ---------------------------------------------------------------------------
// Edge delta varint encoder: controller
// Takes one edge in idle, then steps the datapath through its bytes.
// ---------------------------------------------------------------------------
module edvenc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  edvenc_pkg::sts_t   sts,
  output edvenc_pkg::cmd_t   cmd
);
  import edvenc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && !sts.zero_gap) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free && sts.last_byte) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_EMIT: begin
        cmd.emit = sts.slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/edvenc_dp.sv
// ---------------------------------------------------------------------------
// Edge delta varint encoder: datapath
// Holds the magnitude still to code and the running offset, forms one
// byte per step and keeps the output register.
// ---------------------------------------------------------------------------
module edvenc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_action,
  input  logic [edvenc_pkg::SRC_W-1:0]         in_src,
  input  logic [edvenc_pkg::VAL_W-1:0]         in_val,
  input  logic [edvenc_pkg::OFS_W-1:0]         in_ofs,
  input  edvenc_pkg::cmd_t                     cmd,
  output edvenc_pkg::sts_t                     sts,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [edvenc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                 out_tlast
);
  import edvenc_pkg::*;

  logic [VAL_W-1:0]  mag_r;
  logic [OFS_W-1:0]  ofs_r;
  logic              first_r;
  logic              neg_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic [OFS_W-1:0]  out_ofs_r;
  logic              out_last_r;

  logic [VAL_W-1:0]  src_ext;
  logic              load_neg;
  logic [VAL_W-1:0]  load_mag;
  logic [VAL_W-1:0]  rest;
  logic              more;
  logic [BYTE_W-1:0] code_byte;

  // first edge: signed difference target minus source, as sign and magnitude; a gap is taken as is
  always_comb begin
    src_ext  = {1'b0, in_src};
    load_neg = (in_action == ACT_FIRST) && (in_val < src_ext);
    if (in_action == ACT_GAP) begin
      load_mag = in_val;
    end else if (load_neg) begin
      load_mag = src_ext - in_val;
    end else begin
      load_mag = in_val - src_ext;
    end
  end

  // first byte of a first edge carries six bits and the sign, others seven
  always_comb begin
    rest = first_r ? {6'b0, mag_r[VAL_W-1:6]} : {7'b0, mag_r[VAL_W-1:7]};
    more = (rest != '0);
    if (first_r) begin
      code_byte = (mag_r[BYTE_W-1:0] & LOW6_MASK) | (neg_r ? SIGN_BIT : '0);
    end else begin
      code_byte = mag_r[BYTE_W-1:0] & LOW7_MASK;
    end
    code_byte = code_byte | (more ? CONT_BIT : '0);
  end

  always_comb begin
    sts.zero_gap  = (in_action == ACT_GAP) && (in_val == '0);
    sts.slot_free = !out_valid_r || out_tready;
    sts.last_byte = !more;
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r   <= load_mag;
      ofs_r   <= in_ofs;
      first_r <= (in_action == ACT_FIRST);
      neg_r   <= load_neg;
    end else if (cmd.emit) begin
      mag_r   <= rest;
      ofs_r   <= ofs_r + {{(OFS_W-1){1'b0}}, 1'b1};
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= code_byte;
      out_ofs_r  <= ofs_r;
      out_last_r <= !more;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ofs_r, out_byte_r};
  assign out_tlast  = out_last_r;

endmodule

### hw/rtl/edge_delta_varint_encoder.sv
// ---------------------------------------------------------------------------
// Edge delta varint encoder: top level
// Codes one adjacency-list edge per input word as varint bytes, each
// tagged with its write offset.
//
//   channel | dir | tdata (low bit up)                     | tuser  | tlast
//   in_     | in  | source_vertex, edge_value, write_offset | action | -
//   out_    | out | out_byte, byte_offset                  | -      | last
//
// An edge is loaded in idle, then codes to 1 to 5 bytes, one byte per cycle
// while the output register is free; a zero gap is taken without leaving
// idle. The datapath has a single byte register. A new edge is taken while
// the final byte of the previous one still waits. Output stalls hold the
// byte register. Reset (synchronous, active low) clears the controller and
// the output valid flag only.
// ---------------------------------------------------------------------------
module edge_delta_varint_encoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // source_vertex[30:0], edge_value[62:31], write_offset[110:63], pad
  input  logic [edvenc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_byte[7:0], byte_offset[55:8]
  output logic [edvenc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                 out_tlast
);
  import edvenc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  edvenc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  edvenc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_tuser),
    .in_src     (in_tdata[SRC_W-1:0]),
    .in_val     (in_tdata[SRC_W+VAL_W-1:SRC_W]),
    .in_ofs     (in_tdata[SRC_W+VAL_W+OFS_W-1:SRC_W+VAL_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### hw/rtl/edvenc_checker.sv
// ---------------------------------------------------------------------------
// Edge delta varint encoder: port checker
// Watches the top-level ports for byte ordering and handshake behaviour.
// ---------------------------------------------------------------------------
`include "edge_delta_varint_encoder_assert.svh"

module edvenc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [111:0] in_tdata,
  input logic         in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [55:0]  out_tdata,
  input logic         out_tlast
);

  // a stalled word holds
  `EDV_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // continuation bit is set on every byte but the last
  `EDV_ASSERT_IMP(a_cont_bit, clk, rst_n, out_tvalid, out_tlast == !out_tdata[7])

  // a taken non-final byte is followed at once by the next offset
  `EDV_ASSERT_NXT(a_next_byte, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tdata[55:8] == $past(out_tdata[55:8]) + 48'd1))

  // an edge that codes to bytes blocks input while it is worked
  `EDV_ASSERT_NXT(a_busy, clk, rst_n, in_tvalid && in_tready && !(in_tuser && (in_tdata[62:31] == 32'd0)), !in_tready)

endmodule

bind edge_delta_varint_encoder edvenc_checker u_chk (.*);

### test/testbench.sv
// ---------------------------------------------------------------------------
// Edge delta varint encoder: testbench
// Drives first-edge and gap words into the encoder and predicts every coded
// byte, with its write offset and final-byte flag. Each word that leaves the
// block is checked against the oldest prediction. In two tests both sides
// idle at random; the receiver holds off once for long enough to stall input.
// ---------------------------------------------------------------------------
module testbench;
  import edvenc_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] code;
    logic [OFS_W-1:0]  offset;
    logic              last_flag;
  } coded_byte_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  coded_byte_t expected_bytes[$];
  int          fail_count;
  int          edges_sent;
  int          zero_gaps;
  int          negative_deltas;
  int          bytes_checked;
  bit          in_gaps;
  bit          out_gaps;
  int          hold_cycles;

  edge_delta_varint_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Predict the coded bytes of one edge and queue them.
  function automatic void encode_edge(logic act, logic [SRC_W-1:0] src,
                                      logic [VAL_W-1:0] val, logic [OFS_W-1:0] ofs);
    logic [VAL_W-1:0]  mag;
    logic              neg;
    logic [BYTE_W-1:0] b;
    coded_byte_t       seq[$];
    coded_byte_t       cb;
    int                k;
    neg = (act == ACT_FIRST) && (val < {1'b0, src});
    if (act == ACT_FIRST) begin
      mag = neg ? ({1'b0, src} - val) : (val - {1'b0, src});
      b = mag[BYTE_W-1:0] & LOW6_MASK;
      if (neg) b = b | SIGN_BIT;
      mag = mag >> 6;
      if (mag != 0) b = b | CONT_BIT;
      cb.code = b;
      seq.push_back(cb);
    end else begin
      mag = val;
    end
    while (mag != 0) begin
      b = mag[BYTE_W-1:0] & LOW7_MASK;
      mag = mag >> 7;
      if (mag != 0) b = b | CONT_BIT;
      cb.code = b;
      seq.push_back(cb);
    end
    if (neg) negative_deltas++;
    if (seq.size() == 0) zero_gaps++;
    for (k = 0; k < seq.size(); k++) begin
      cb = seq[k];
      cb.offset = ofs + k;
      cb.last_flag = (k == seq.size() - 1);
      expected_bytes.push_back(cb);
    end
  endfunction

  task automatic send_edge(logic act, logic [SRC_W-1:0] src,
                           logic [VAL_W-1:0] val, logic [OFS_W-1:0] ofs);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, ofs, val, src};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    encode_edge(act, src, val, ofs);
    edges_sent++;
  endtask

  // Drop valid, then wait for every predicted byte to leave the block.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_bits(int width);
    logic [VAL_W-1:0] mask;
    mask = (width >= VAL_W) ? '1 : ((VAL_W'(1) << width) - 1);
    return $urandom & mask;
  endfunction

  task automatic send_random_edge;
    logic             act;
    logic [SRC_W-1:0] src;
    logic [VAL_W-1:0] val;
    logic [OFS_W-1:0] ofs;
    act = 1'($urandom_range(0, 1));
    src = SRC_W'(rand_bits($urandom_range(0, SRC_W)));
    val = rand_bits($urandom_range(0, VAL_W));
    if ($urandom_range(0, 7) == 0) val = {1'b0, src} + $urandom_range(0, 3) - 1;
    if ($urandom_range(0, 9) == 0)
      ofs = '1 - $urandom_range(0, 6);
    else
      ofs = {16'($urandom_range(0, 16'hffff)), 32'($urandom)};
    send_edge(act, src, val, ofs);
  endtask

  task automatic test_directed;
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    send_edge(ACT_FIRST, 31'd5, 32'd5, 48'd0);               // zero difference
    send_edge(ACT_FIRST, 31'd0, 32'd0, 48'd1);
    send_edge(ACT_FIRST, 31'd0, 32'd63, 48'd10);
    send_edge(ACT_FIRST, 31'd0, 32'd64, 48'd20);
    send_edge(ACT_FIRST, 31'd1, 32'd0, 48'd30);
    send_edge(ACT_FIRST, 31'd100, 32'd37, 48'd40);
    send_edge(ACT_FIRST, 31'd64, 32'd0, 48'd50);
    send_edge(ACT_FIRST, 31'd0, 32'hffff_ffff, 48'd60);      // target above 31 bits
    send_edge(ACT_FIRST, 31'h7fff_ffff, 32'd0, 48'd70);
    send_edge(ACT_FIRST, 31'h7fff_ffff, 32'hffff_ffff, 48'h7fff_ffff_ffff);
    send_edge(ACT_GAP, 31'h7fff_ffff, 32'd0, 48'd80);        // zero gap
    send_edge(ACT_GAP, 31'd0, 32'd1, 48'd90);
    send_edge(ACT_GAP, 31'd0, 32'd127, 48'd100);
    send_edge(ACT_GAP, 31'd0, 32'd128, 48'd110);
    send_edge(ACT_GAP, 31'd0, 32'h0fff_ffff, 48'd120);
    send_edge(ACT_GAP, 31'd0, 32'h1000_0000, 48'd130);
    send_edge(ACT_GAP, 31'd0, 32'hffff_ffff, 48'hffff_ffff_fffe);  // offset wrap
    send_edge(ACT_GAP, 31'd0, 32'd0, 48'hffff_ffff_ffff);
    send_edge(ACT_GAP, 31'h2aaa_aaaa, 32'd0, 48'd140);
    send_edge(ACT_FIRST, 31'h2aaa_aaaa, 32'h5555_5555, 48'hffff_ffff_ffff);
    send_edge(ACT_FIRST, 31'h5555_5555, 32'haaaa_aaaa, 48'haaaa_aaaa_aaaa);
    drain();
  endtask

  task automatic test_random;
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    repeat (170) send_random_edge();
    drain();
  endtask

  // Receiver holds off while the sender keeps offering edges.
  task automatic test_backpressure;
    in_gaps     = 1'b0;
    out_gaps    = 1'b0;
    hold_cycles = 300;
    repeat (25) send_edge(ACT_GAP, 31'd0, 32'hffff_ffff, 48'($urandom));
    drain();
  endtask

  task automatic test_full_rate;
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    repeat (45) send_random_edge();
    drain();
  endtask

  // Receiver: random stall bursts and one long hold when asked.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        stall_left  = hold_cycles;
        hold_cycles = 0;
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (out_gaps && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_bytes
    coded_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected word: out_byte %h byte_offset %h last %b",
               out_tdata[BYTE_W-1:0], out_tdata[OUT_TDATA_W-1:BYTE_W], out_tlast);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_tdata[BYTE_W-1:0] !== want.code) begin
          $error("out_byte: expected %h, got %h", want.code, out_tdata[BYTE_W-1:0]);
          fail_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:BYTE_W] !== want.offset) begin
          $error("byte_offset: expected %h, got %h", want.offset,
                 out_tdata[OUT_TDATA_W-1:BYTE_W]);
          fail_count++;
        end
        if (out_tlast !== want.last_flag) begin
          $error("last: expected %b, got %b", want.last_flag, out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count      = 0;
    edges_sent      = 0;
    zero_gaps       = 0;
    negative_deltas = 0;
    bytes_checked   = 0;
    in_gaps         = 1'b0;
    out_gaps        = 1'b0;
    hold_cycles     = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    out_tready <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();
    test_backpressure();
    test_full_rate();

    $display("Encoded %0d edges: %0d negative first-edge deltas, %0d zero gaps.",
             edges_sent, negative_deltas, zero_gaps);
    $display("Checked %0d coded bytes under random stalls and one long hold-off.",
             bytes_checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
